// File: rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants of the triangle face normal pipeline: the words
// handed from cell to cell in the square root and divider chains.
// ----------------------------------------------------------------------------
package tfn_pkg;

    // Normalized cross component width and output fraction
    localparam int TARGET_BITS = 30;
    localparam int FRAC_OUT    = 14;
    localparam int OUT_W       = 16;

    // Squared length, root and square root remainder widths
    localparam int S_W      = 2 * TARGET_BITS + 2;
    localparam int R_W      = S_W / 2;
    localparam int SQ_REM_W = R_W + 2;

    // Divider: quotient bits, divisor and remainder widths
    localparam int Q_W      = FRAC_OUT + 1;
    localparam int D_W      = R_W + 1;

    // Word moving through the square root cells
    typedef struct packed {
        logic                             vld;
        logic                             degen;
        logic [2:0]                       neg;
        logic [2:0][TARGET_BITS-1:0]      m;
        logic [S_W-1:0]                   s;
        logic [SQ_REM_W-1:0]              rem;
        logic [R_W-1:0]                   root;
    } t_sq_word;

    // Word moving through the divider cells
    typedef struct packed {
        logic                             vld;
        logic                             degen;
        logic [2:0]                       neg;
        logic [D_W-1:0]                   d;
        logic [2:0][Q_W-1:0]              nlo;
        logic [2:0][D_W-1:0]              rem;
        logic [2:0][Q_W-1:0]              q;
    } t_dv_word;

endpackage

// File: rtl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit flat normal of a triangle in Q2.14 from three Q8.8 corners.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle and returns one word per triangle, in order,
// and stalls its input while the skid word is held. The path
// is a seven stage front end (edges, products, cross product, bit length,
// block shift to 30 bits, squares, sum), a chain of 31 square root cells
// (one root bit each), a divider setup stage, a chain of 15 divider cells
// (one quotient bit each for all three components), a sign stage and an
// output register with a one word skid buffer. A collinear or coincident
// triangle gives a zero normal with the degenerate flag set in tuser.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
    input  logic [((9 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // normal_x, normal_y, normal_z from the lowest bit up
    output logic [3 * tfn_pkg::OUT_W - 1:0]         m_axis_tdata,
    // degenerate
    output logic                                    m_axis_tuser
);

    localparam int R_W  = tfn_pkg::R_W;
    localparam int Q_W  = tfn_pkg::Q_W;
    localparam int OW   = tfn_pkg::OUT_W;
    localparam int TB   = tfn_pkg::TARGET_BITS;
    localparam int NW   = TB + Q_W + 1;
    localparam int ODW  = 3 * OW + 1;

    logic                        w_en;
    logic [8:0][COORD_WIDTH-1:0] w_coord;
    tfn_pkg::t_sq_word           w_sq [0:R_W];
    tfn_pkg::t_dv_word           w_dv [0:Q_W];
    tfn_pkg::t_dv_word           r_prep;
    tfn_pkg::t_dv_word           n_prep;
    logic                        r_fin_vld;
    logic [ODW-1:0]              r_fin;
    logic [ODW-1:0]              n_fin;
    logic                        r_ov;
    logic [ODW-1:0]              r_od;
    logic                        r_skv;
    logic [ODW-1:0]              r_skd;

    // Stall the whole pipeline only while the skid word is held
    assign w_en          = !r_skv;
    assign s_axis_tready = w_en;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_coord[i] = s_axis_tdata[i * COORD_WIDTH +: COORD_WIDTH];
        end
    end

    tfn_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (s_axis_tvalid),
        .i_coord(w_coord),
        .o_word (w_sq[0])
    );

    // Square root chain, most significant root bit first
    for (genvar k = 0; k < R_W; k++) begin : g_sqrt
        tfn_sqrt_cell #(
            .BIT(R_W - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_word (w_sq[k]),
            .o_word (w_sq[k + 1])
        );
    end

    // Set up dividend (m << 15) + R and divisor 2R
    always_comb begin
        logic [NW-1:0] nn;
        n_prep       = '0;
        n_prep.vld   = w_sq[R_W].vld;
        n_prep.degen = w_sq[R_W].degen;
        n_prep.neg   = w_sq[R_W].neg;
        n_prep.d     = {w_sq[R_W].root, 1'b0};
        for (int i = 0; i < 3; i++) begin
            nn            = {w_sq[R_W].m[i], Q_W'(0)} + NW'(w_sq[R_W].root);
            n_prep.nlo[i] = nn[Q_W-1:0];
            n_prep.rem[i] = tfn_pkg::D_W'(nn[NW-1:Q_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else if (w_en) begin
            r_prep.vld <= n_prep.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep.degen <= n_prep.degen;
            r_prep.neg   <= n_prep.neg;
            r_prep.d     <= n_prep.d;
            r_prep.nlo   <= n_prep.nlo;
            r_prep.rem   <= n_prep.rem;
            r_prep.q     <= n_prep.q;
        end
    end

    assign w_dv[0] = r_prep;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        tfn_div_cell #(
            .BIT(Q_W - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_word (w_dv[k]),
            .o_word (w_dv[k + 1])
        );
    end

    // Clamp, apply sign, zero a degenerate triangle
    always_comb begin
        logic [Q_W-1:0] q;
        logic [OW-1:0]  v;
        n_fin = '0;
        for (int i = 0; i < 3; i++) begin
            q = w_dv[Q_W].q[i];
            if (q > Q_W'(1 << tfn_pkg::FRAC_OUT)) begin
                q = Q_W'(1 << tfn_pkg::FRAC_OUT);
            end
            v = w_dv[Q_W].neg[i] ? OW'(-OW'(q)) : OW'(q);
            if (w_dv[Q_W].degen) begin
                v = '0;
            end
            n_fin[i * OW +: OW] = v;
        end
        n_fin[ODW-1] = w_dv[Q_W].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (w_en) begin
            r_fin_vld <= w_dv[Q_W].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
    end

    // Output register with skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (m_axis_tready) begin
                r_od  <= r_skd;
                r_skv <= 1'b0;
            end
        end else if (r_fin_vld) begin
            if (!r_ov || m_axis_tready) begin
                r_od <= r_fin;
                r_ov <= 1'b1;
            end else begin
                r_skd <= r_fin;
                r_skv <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od[3 * OW - 1:0];
    assign m_axis_tuser  = r_od[ODW-1];

endmodule

// File: rtl/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Edge vectors, exact cross product, block normalization to 30 bits and the
// squared length, as a seven stage pipeline feeding the square root chain.
// ----------------------------------------------------------------------------
module tfn_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [8:0][COORD_WIDTH-1:0]       i_coord,
    output tfn_pkg::t_sq_word                 o_word
);

    localparam int EW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * EW;
    localparam int MW  = 2 * COORD_WIDTH + 2;
    localparam int LW  = $clog2(MW + 1);
    localparam int TB  = tfn_pkg::TARGET_BITS;
    localparam int SQW = 2 * TB;
    localparam int NST = 7;

    logic [NST-1:0]               r_vld;
    logic signed [EW-1:0]         r_e [6];
    logic signed [EW-1:0]         n_e [6];
    logic signed [PW-1:0]         r_p [6];
    logic [MW-1:0]                r_mag [3];
    logic [MW-1:0]                n_mag [3];
    logic [2:0]                   r_neg3, r_neg4, r_neg5, r_neg6, r_neg7;
    logic [2:0]                   n_neg;
    logic [MW-1:0]                r_mag4 [3];
    logic [LW-1:0]                r_l;
    logic [LW-1:0]                n_l;
    logic                         r_dg4, r_dg5, r_dg6, r_dg7;
    logic [TB-1:0]                r_m5 [3];
    logic [TB-1:0]                r_m6 [3];
    logic [TB-1:0]                r_m7 [3];
    logic [SQW-1:0]               r_sq [3];
    logic [tfn_pkg::S_W-1:0]      r_sum;
    logic [MW-1:0]                w_or;

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // Edge vectors from the first corner
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[i]     = EW'(signed'(i_coord[3 + i])) - EW'(signed'(i_coord[i]));
            n_e[3 + i] = EW'(signed'(i_coord[6 + i])) - EW'(signed'(i_coord[i]));
        end
    end

    // Cross difference, sign and magnitude
    always_comb begin
        logic signed [PW:0] c [3];
        c[0] = (PW + 1)'(r_p[0]) - (PW + 1)'(r_p[1]);
        c[1] = (PW + 1)'(r_p[2]) - (PW + 1)'(r_p[3]);
        c[2] = (PW + 1)'(r_p[4]) - (PW + 1)'(r_p[5]);
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = c[i][PW];
            n_mag[i] = c[i][PW] ? MW'(-c[i]) : MW'(c[i]);
        end
    end

    // Bit length of the largest magnitude
    assign w_or = r_mag[0] | r_mag[1] | r_mag[2];
    always_comb begin
        n_l = '0;
        for (int i = 0; i < MW; i++) begin
            if (w_or[i]) begin
                n_l = LW'(i + 1);
            end
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= n_e;
            r_p[0] <= r_e[1] * r_e[5];
            r_p[1] <= r_e[2] * r_e[4];
            r_p[2] <= r_e[2] * r_e[3];
            r_p[3] <= r_e[0] * r_e[5];
            r_p[4] <= r_e[0] * r_e[4];
            r_p[5] <= r_e[1] * r_e[3];
            r_mag  <= n_mag;
            r_neg3 <= n_neg;
            r_mag4 <= r_mag;
            r_l    <= n_l;
            r_dg4  <= (w_or == '0);
            r_neg4 <= r_neg3;
            for (int i = 0; i < 3; i++) begin
                r_m5[i] <= TB'({r_mag4[i], TB'(0)} >> r_l);
                r_sq[i] <= SQW'(r_m5[i]) * SQW'(r_m5[i]);
            end
            r_dg5  <= r_dg4;
            r_neg5 <= r_neg4;
            r_m6   <= r_m5;
            r_dg6  <= r_dg5;
            r_neg6 <= r_neg5;
            r_sum  <= tfn_pkg::S_W'(r_sq[0]) + tfn_pkg::S_W'(r_sq[1])
                    + tfn_pkg::S_W'(r_sq[2]);
            r_m7   <= r_m6;
            r_dg7  <= r_dg6;
            r_neg7 <= r_neg6;
        end
    end

    // Hand the word to the first square root cell
    always_comb begin
        o_word       = '0;
        o_word.vld   = r_vld[NST-1];
        o_word.degen = r_dg7;
        o_word.neg   = r_neg7;
        for (int i = 0; i < 3; i++) begin
            o_word.m[i] = r_m7[i];
        end
        o_word.s     = r_sum;
    end

endmodule

// File: rtl/tfn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One digit of the restoring square root: takes two radicand bits and
// decides one root bit, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tfn_pkg::t_sq_word i_word,
    output tfn_pkg::t_sq_word o_word
);

    localparam int SHW = tfn_pkg::SQ_REM_W + 2;

    tfn_pkg::t_sq_word r_word;
    tfn_pkg::t_sq_word n_word;

    // Trial subtract of (root << 2) | 1
    always_comb begin
        logic [SHW-1:0] sh;
        logic [SHW-1:0] trial;
        sh     = {i_word.rem, i_word.s[2 * BIT + 1 -: 2]};
        trial  = SHW'({i_word.root, 2'b01});
        n_word = i_word;
        if (sh >= trial) begin
            n_word.rem  = tfn_pkg::SQ_REM_W'(sh - trial);
            n_word.root = {i_word.root[tfn_pkg::R_W-2:0], 1'b1};
        end else begin
            n_word.rem  = tfn_pkg::SQ_REM_W'(sh);
            n_word.root = {i_word.root[tfn_pkg::R_W-2:0], 1'b0};
        end
    end

    // Hold the word for the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word.vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word.degen <= n_word.degen;
            r_word.neg   <= n_word.neg;
            r_word.m     <= n_word.m;
            r_word.s     <= n_word.s;
            r_word.rem   <= n_word.rem;
            r_word.root  <= n_word.root;
        end
    end

    assign o_word = r_word;

endmodule

// File: rtl/tfn_div_cell.sv
// ----------------------------------------------------------------------------
// tfn_div_cell
// One quotient bit of the restoring divider for all three components,
// then hand the word to the next cell.
// ----------------------------------------------------------------------------
module tfn_div_cell #(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tfn_pkg::t_dv_word i_word,
    output tfn_pkg::t_dv_word o_word
);

    localparam int SHW = tfn_pkg::D_W + 1;

    tfn_pkg::t_dv_word r_word;
    tfn_pkg::t_dv_word n_word;

    // Shift in the next dividend bit and try the divisor
    always_comb begin
        logic [SHW-1:0] sh;
        n_word = i_word;
        for (int i = 0; i < 3; i++) begin
            sh = {i_word.rem[i], i_word.nlo[i][BIT]};
            if (sh >= SHW'(i_word.d)) begin
                n_word.rem[i] = tfn_pkg::D_W'(sh - SHW'(i_word.d));
                n_word.q[i]   = i_word.q[i] | (tfn_pkg::Q_W'(1) << BIT);
            end else begin
                n_word.rem[i] = tfn_pkg::D_W'(sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word.vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word.degen <= n_word.degen;
            r_word.neg   <= n_word.neg;
            r_word.d     <= n_word.d;
            r_word.nlo   <= n_word.nlo;
            r_word.rem   <= n_word.rem;
            r_word.q     <= n_word.q;
        end
    end

    assign o_word = r_word;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of triangle_face_normal against an in-bench normal predictor.
// ----------------------------------------------------------------------------
// A queue of triangles (directed corner cases, then random, small and collinear
// ones) feeds a clocked driver with random gaps. A clocked monitor with random
// ready stalls compares every output word field by field with the oldest
// predicted normal. One long ready hold-off fills the pipe, and the sender
// pauses once until every pending normal has drained.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW        = 16;
    localparam int IN_W      = ((9 * CW + 7) / 8) * 8;
    localparam int OW        = tfn_pkg::OUT_W;
    localparam int FRAC      = tfn_pkg::FRAC_OUT;
    localparam int TGT       = tfn_pkg::TARGET_BITS;
    localparam int N_RANDOM  = 1080;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = 120;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 400;
    localparam int PAUSE_AT  = 650;

    typedef struct packed {
        logic [2:0][2:0][CW-1:0] p;   // corner, then x/y/z
    } t_tri;

    typedef struct packed {
        logic [2:0][OW-1:0] n;
        logic               degen;
    } t_normal;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [3*OW-1:0]     m_axis_tdata;
    logic                m_axis_tuser;

    t_tri    tri_q[$];
    t_normal normal_q[$];
    int      n_errors;
    int      n_sent;
    int      n_recv;
    bit      stim_done;
    bit      burst;

    triangle_face_normal #(.COORD_WIDTH(CW)) dut (.*);

    // Clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Exact cross product, block shift to 30 bits, root and rounded divide
    function automatic t_normal face_normal(t_tri t);
        longint            e1[3];
        longint            e2[3];
        longint            cr[3];
        longint unsigned   mag[3];
        longint unsigned   sq_sum;
        longint unsigned   root;
        longint unsigned   bitv;
        longint unsigned   q;
        longint unsigned   v;
        int                blen;
        int                l;
        t_normal           r;
        for (int k = 0; k < 3; k++) begin
            e1[k] = longint'($signed(t.p[1][k])) - longint'($signed(t.p[0][k]));
            e2[k] = longint'($signed(t.p[2][k])) - longint'($signed(t.p[0][k]));
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        blen = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (cr[k] < 0) ? -cr[k] : cr[k];
            l = 0;
            v = mag[k];
            while (v != 0) begin
                l++;
                v >>= 1;
            end
            if (l > blen) blen = l;
        end
        r = '0;
        if (blen == 0) begin
            r.degen = 1'b1;
            return r;
        end
        sq_sum = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (blen > TGT) ? (mag[k] >> (blen - TGT)) : (mag[k] << (TGT - blen));
            sq_sum += mag[k] * mag[k];
        end
        // Bitwise integer square root
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > sq_sum) bitv >>= 2;
        while (bitv != 0) begin
            if (sq_sum >= root + bitv) begin
                sq_sum -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << (FRAC + 1)) + root) / (2 * root);
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            r.n[k] = (cr[k] < 0) ? OW'(-q) : OW'(q);
        end
        return r;
    endfunction

    function automatic t_tri make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        t_tri t;
        t.p[0] = {CW'(az), CW'(ay), CW'(ax)};
        t.p[1] = {CW'(bz), CW'(by), CW'(bx)};
        t.p[2] = {CW'(cz), CW'(cy), CW'(cx)};
        return t;
    endfunction

    function automatic int rnd_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Fill the triangle queue
    initial begin
        t_tri t;
        int   ax, ay, az, dx, dy, dz, k, kind, span;
        tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_q.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
        tri_q.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        tri_q.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        tri_q.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
        tri_q.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
        tri_q.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
        tri_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        tri_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1));
        tri_q.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                 -32768, 32767, -32768));
        tri_q.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                 32767, -32768, 32767));
        tri_q.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                                 32767, -32768, 32767));
        tri_q.push_back(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                                 32767, 32767, -32768));
        tri_q.push_back(make_tri(-32768, 0, 32767, 32767, 0, -32768, 0, 32767, 0));
        tri_q.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                 32767, 32767, 32767));
        tri_q.push_back(make_tri(1, 2, 3, 4, 6, 8, 7, 10, 13));
        tri_q.push_back(make_tri(0, 0, 0, 3, 4, 0, 0, 0, 1));
        tri_q.push_back(make_tri(0, 0, 0, 1, 1, 0, -1, 1, 0));
        tri_q.push_back(make_tri(100, -200, 300, -400, 500, -600, 700, 800, -900));
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            span = (kind < 5) ? 32768 : ((kind < 8) ? $urandom_range(1, 64) : 200);
            for (int c = 0; c < 3; c++) begin
                t.p[c] = {CW'(rnd_coord(span)), CW'(rnd_coord(span)), CW'(rnd_coord(span))};
            end
            if (kind == 8) begin
                // Collinear corners: third corner on the line through the first two
                ax = rnd_coord(8000); ay = rnd_coord(8000); az = rnd_coord(8000);
                dx = rnd_coord(300); dy = rnd_coord(300); dz = rnd_coord(300);
                k  = rnd_coord(40);
                t = make_tri(ax, ay, az, ax + dx, ay + dy, az + dz,
                             ax + k * dx, ay + k * dy, az + k * dz);
            end else if (kind == 9 && $urandom_range(0, 3) == 0) begin
                t.p[2] = t.p[$urandom_range(0, 1)];
            end
            tri_q.push_back(t);
        end
        stim_done = 1'b1;
    end

    // Drive triangles with random gaps and one drain pause
    int  gap_cnt;
    bit  paused_once;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_cnt        = 0;
            burst          = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                normal_q.push_back(face_normal(t_tri'(s_axis_tdata)));
                n_sent++;
                if (n_sent % 150 == 0) burst = ~burst;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (n_sent == PAUSE_AT && !paused_once && normal_q.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_axis_tvalid <= 1'b0;
                end else if (tri_q.size() != 0) begin
                    if (n_sent == PAUSE_AT) paused_once = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tri_q.pop_front();
                    gap_cnt        = burst ? 0 : $urandom_range(0, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check output words and stall the output side
    int  rdy_wait;
    int  hold_cnt;
    bit  held_once;
    always @(posedge i_clk) begin
        t_normal got;
        t_normal want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rdy_wait       = 0;
            hold_cnt       = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tuser};
                n_recv++;
                if (normal_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected word %h/%b", m_axis_tdata, m_axis_tuser);
                end else begin
                    want = normal_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("word %0d: exp x=%h y=%h z=%h dg=%b got x=%h y=%h z=%h dg=%b",
                                     n_recv, want.n[0], want.n[1], want.n[2], want.degen,
                                     got.n[0], got.n[1], got.n[2], got.degen);
                    end
                end
                rdy_wait = burst ? 0 : $urandom_range(0, 8);
            end
            if (n_sent >= HOLD_AT && !held_once) begin
                held_once = 1'b1;
                hold_cnt  = HOLD_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (rdy_wait > 0) begin
                rdy_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Reset, drain and verdict
    initial begin
        int cyc;
        n_errors  = 0;
        n_sent    = 0;
        n_recv    = 0;
        i_rst_n   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cyc = 0;
        while (!(stim_done && tri_q.size() == 0 && !s_axis_tvalid && normal_q.size() == 0)
               && cyc < CYC_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        if (cyc >= CYC_LIMIT) begin
            $display("Simulation FAILED");
        end else begin
            repeat (DRAIN) @(posedge i_clk);
            if (n_errors == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule
